// ----- hdl/srsa_pkg.sv -----
// Shared types, constants, prime table and microcode for the small RSA block.
package srsa_pkg;

  localparam int unsigned PRIME_LIMIT = 49;

  localparam int unsigned PrimeW = 6;
  localparam int unsigned ValW   = 11;
  localparam int unsigned ModW   = 12;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CntW   = 4;
  localparam int unsigned PcW    = 5;

  localparam logic [CntW-1:0] RemSteps = CntW'(ValW);
  localparam logic [CntW-1:0] MulSteps = CntW'(ByteW);

  typedef enum logic [0:0] {
    REG_PRIME_P = 1'b0,
    REG_PRIME_Q = 1'b1
  } srsa_reg_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_INIT_KEY,
    OP_E_START,
    OP_REM_INIT,
    OP_REM_STEP,
    OP_E_INC,
    OP_D_START,
    OP_D_STEP,
    OP_KEY_OK,
    OP_Z_INIT,
    OP_MUL_INIT,
    OP_MUL_STEP,
    OP_MUL_DONE,
    OP_OUT_LOAD
  } srsa_op_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_KEY_READY,
    C_BAD_PRIMES,
    C_E_GE_FI,
    C_E_NOT_PRIME,
    C_CNT_GT1,
    C_R_NZ,
    C_R_ONE,
    C_SKIP_ENC,
    C_K_ZERO,
    C_OUT_BUSY
  } srsa_cond_e;

  typedef struct packed {
    srsa_op_e         op;
    srsa_cond_e       cond;
    logic [PcW-1:0]   target;
  } srsa_uword_t;

  // Status from the datapath that the sequencer branches on.
  typedef struct packed {
    logic in_valid;
    logic key_ready;
    logic bad_primes;
    logic e_ge_fi;
    logic e_not_prime;
    logic cnt_gt1;
    logic r_nz;
    logic r_one;
    logic skip_enc;
    logic k_zero;
    logic out_busy;
  } srsa_flags_t;

  // Program labels
  localparam logic [PcW-1:0] L_IDLE   = 5'd0;
  localparam logic [PcW-1:0] L_ETEST  = 5'd4;
  localparam logic [PcW-1:0] L_REM    = 5'd7;
  localparam logic [PcW-1:0] L_ENEXT  = 5'd9;
  localparam logic [PcW-1:0] L_EFOUND = 5'd10;
  localparam logic [PcW-1:0] L_DTEST  = 5'd11;
  localparam logic [PcW-1:0] L_DFOUND = 5'd13;
  localparam logic [PcW-1:0] L_ENC    = 5'd14;
  localparam logic [PcW-1:0] L_ELOOP  = 5'd15;
  localparam logic [PcW-1:0] L_MUL    = 5'd17;
  localparam logic [PcW-1:0] L_OUT    = 5'd19;

  function automatic logic is_prime6(input logic [PrimeW-1:0] v);
    logic r;
    case (v)
      6'd2, 6'd3, 6'd5, 6'd7, 6'd11, 6'd13, 6'd17, 6'd19, 6'd23, 6'd29,
      6'd31, 6'd37, 6'd41, 6'd43, 6'd47, 6'd53, 6'd59, 6'd61: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic srsa_uword_t mk(input srsa_op_e op, input srsa_cond_e c,
                                     input logic [PcW-1:0] t);
    srsa_uword_t w;
    w.op     = op;
    w.cond   = c;
    w.target = t;
    return w;
  endfunction

  // Microcode: do op, then jump to target if cond holds, else fall through.
  function automatic srsa_uword_t ucode_rom(input logic [PcW-1:0] pc);
    srsa_uword_t w;
    case (pc)
      5'd0:  w = mk(OP_ACCEPT,   C_NO_IN,       L_IDLE);
      5'd1:  w = mk(OP_NOP,      C_KEY_READY,   L_ENC);
      5'd2:  w = mk(OP_INIT_KEY, C_BAD_PRIMES,  L_ENC);
      5'd3:  w = mk(OP_E_START,  C_NEVER,       L_IDLE);
      5'd4:  w = mk(OP_NOP,      C_E_GE_FI,     L_ENC);   // no coprime e: error
      5'd5:  w = mk(OP_NOP,      C_E_NOT_PRIME, L_ENEXT);
      5'd6:  w = mk(OP_REM_INIT, C_NEVER,       L_IDLE);
      5'd7:  w = mk(OP_REM_STEP, C_CNT_GT1,     L_REM);
      5'd8:  w = mk(OP_NOP,      C_R_NZ,        L_EFOUND);
      5'd9:  w = mk(OP_E_INC,    C_ALWAYS,      L_ETEST);
      5'd10: w = mk(OP_D_START,  C_NEVER,       L_IDLE);
      5'd11: w = mk(OP_NOP,      C_R_ONE,       L_DFOUND);
      5'd12: w = mk(OP_D_STEP,   C_ALWAYS,      L_DTEST);
      5'd13: w = mk(OP_KEY_OK,   C_ALWAYS,      L_ENC);
      5'd14: w = mk(OP_Z_INIT,   C_SKIP_ENC,    L_OUT);
      5'd15: w = mk(OP_NOP,      C_K_ZERO,      L_OUT);
      5'd16: w = mk(OP_MUL_INIT, C_NEVER,       L_IDLE);
      5'd17: w = mk(OP_MUL_STEP, C_CNT_GT1,     L_MUL);
      5'd18: w = mk(OP_MUL_DONE, C_ALWAYS,      L_ELOOP);
      5'd19: w = mk(OP_NOP,      C_OUT_BUSY,    L_OUT);
      5'd20: w = mk(OP_OUT_LOAD, C_ALWAYS,      L_IDLE);
      default: w = mk(OP_NOP,    C_ALWAYS,      L_IDLE);
    endcase
    return w;
  endfunction

endpackage

// ----- hdl/srsa_seq.sv -----
// Microcode sequencer: step counter, control ROM and conditional jumps.
module srsa_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  srsa_pkg::srsa_flags_t flags_i,
  output srsa_pkg::srsa_op_e  op_o
);
  import srsa_pkg::*;

  logic [PcW-1:0] pc_q, pc_d;
  srsa_uword_t    uw;
  logic           take;

  always_comb begin
    uw = ucode_rom(pc_q);
    case (uw.cond)
      C_NEVER:       take = 1'b0;
      C_ALWAYS:      take = 1'b1;
      C_NO_IN:       take = !flags_i.in_valid;
      C_KEY_READY:   take = flags_i.key_ready;
      C_BAD_PRIMES:  take = flags_i.bad_primes;
      C_E_GE_FI:     take = flags_i.e_ge_fi;
      C_E_NOT_PRIME: take = flags_i.e_not_prime;
      C_CNT_GT1:     take = flags_i.cnt_gt1;
      C_R_NZ:        take = flags_i.r_nz;
      C_R_ONE:       take = flags_i.r_one;
      C_SKIP_ENC:    take = flags_i.skip_enc;
      C_K_ZERO:      take = flags_i.k_zero;
      C_OUT_BUSY:    take = flags_i.out_busy;
      default:       take = 1'b1;
    endcase
    pc_d = take ? uw.target : pc_q + PcW'(1);
    op_o = uw.op;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= L_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// ----- hdl/small_rsa_key_and_encrypt.sv -----
// Top level: textbook RSA key derivation and byte encryption, microcoded.
// The public exponent e is at most 11. The first byte after reset or a prime write also
// derives the key, trying exponent candidates and then private exponent candidates.
// Only one byte is in flight at a time: a new byte is not taken until the last result
// has been loaded into the output register. Reset loads primes 5 and 7; no clearing pass.
module small_rsa_key_and_encrypt (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic                           cfg_index_i,
  input  logic [srsa_pkg::PrimeW-1:0]    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [srsa_pkg::ByteW-1:0]     plain_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [srsa_pkg::ValW-1:0]      cipher_value_o,
  output logic [srsa_pkg::ValW-1:0]      modulus_o,
  output logic [srsa_pkg::ValW-1:0]      public_exp_o,
  output logic [srsa_pkg::ValW-1:0]      private_exp_o,
  output logic                           key_error_o
);
  import srsa_pkg::*;

  srsa_op_e    op;
  srsa_flags_t flags;

  logic [PrimeW-1:0] p_q, q_q;
  logic              derived_q, err_q;
  logic [ModW-1:0]   n_q;
  logic [ValW-1:0]   fi_q, e_q, d_q, r_q, z_q, acc_q, k_q, sh_q;
  logic [CntW-1:0]   cnt_q;
  logic [ByteW-1:0]  m_q;
  logic              out_valid_q;
  logic [ValW-1:0]   oc_q, on_q, oe_q, od_q;
  logic              oerr_q;

  logic              primes_ok;
  logic [ModW-1:0]   rem_t, rem_r, dsum, dsum_r;
  logic [ModW-1:0]   dbl, dbl_r, add, add_r;

  srsa_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .op_o    (op)
  );

  always_comb begin
    primes_ok = is_prime6(p_q) && is_prime6(q_q) && (p_q != q_q) &&
                (ModW'(p_q) <= ModW'(PRIME_LIMIT)) && (ModW'(q_q) <= ModW'(PRIME_LIMIT));

    // one bit of fi mod e
    rem_t = {r_q, sh_q[ValW-1]};
    rem_r = (rem_t >= {1'b0, e_q}) ? rem_t - {1'b0, e_q} : rem_t;

    // running d*e mod fi
    dsum   = {1'b0, r_q} + {1'b0, e_q};
    dsum_r = (dsum >= {1'b0, fi_q}) ? dsum - {1'b0, fi_q} : dsum;

    // one bit of z*m mod n, multiplier bits msb first
    dbl   = {acc_q, 1'b0};
    dbl_r = (dbl >= n_q) ? dbl - n_q : dbl;
    add   = dbl_r + (sh_q[ValW-1] ? {1'b0, z_q} : '0);
    add_r = (add >= n_q) ? add - n_q : add;

    flags.in_valid    = in_valid_i;
    flags.key_ready   = derived_q;
    flags.bad_primes  = !primes_ok;
    flags.e_ge_fi     = (e_q >= fi_q);
    flags.e_not_prime = (e_q[ValW-1:PrimeW] != '0) || !is_prime6(e_q[PrimeW-1:0]);
    flags.cnt_gt1     = (cnt_q > CntW'(1));
    flags.r_nz        = (r_q != '0);
    flags.r_one       = (r_q == ValW'(1));
    flags.skip_enc    = err_q || (n_q == '0);
    flags.k_zero      = (k_q == '0);
    flags.out_busy    = out_valid_q && out_stall_i;
  end

  assign in_stall_o = (op != OP_ACCEPT);

  // control and key state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q         <= PrimeW'(5);
      q_q         <= PrimeW'(7);
      derived_q   <= 1'b0;
      err_q       <= 1'b0;
      n_q         <= '0;
      e_q         <= '0;
      d_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (op)
        OP_INIT_KEY: begin
          n_q       <= ModW'(p_q) * ModW'(q_q);
          e_q       <= '0;
          d_q       <= '0;
          err_q     <= 1'b1;
          derived_q <= 1'b1;
        end
        OP_E_START:  e_q <= ValW'(2);
        OP_E_INC:    e_q <= e_q + ValW'(1);
        OP_D_START:  d_q <= ValW'(1);
        OP_D_STEP:   d_q <= d_q + ValW'(1);
        OP_KEY_OK:   err_q <= 1'b0;
        OP_OUT_LOAD: out_valid_q <= 1'b1;
        default: ;
      endcase
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_PRIME_P: p_q <= cfg_data_i;
          REG_PRIME_Q: q_q <= cfg_data_i;
          default: ;
        endcase
        derived_q <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (op)
      OP_ACCEPT: begin
        if (in_valid_i) begin
          m_q <= plain_byte_i;
        end
      end
      OP_INIT_KEY: fi_q <= (ValW'(p_q) - ValW'(1)) * (ValW'(q_q) - ValW'(1));
      OP_REM_INIT: begin
        r_q   <= '0;
        sh_q  <= fi_q;
        cnt_q <= RemSteps;
      end
      OP_REM_STEP: begin
        r_q   <= rem_r[ValW-1:0];
        sh_q  <= {sh_q[ValW-2:0], 1'b0};
        cnt_q <= cnt_q - CntW'(1);
      end
      OP_D_START: r_q <= e_q;
      OP_D_STEP:  r_q <= dsum_r[ValW-1:0];
      OP_Z_INIT: begin
        z_q <= flags.skip_enc ? '0 : ValW'(1);
        k_q <= e_q;
      end
      OP_MUL_INIT: begin
        acc_q <= '0;
        sh_q  <= {m_q, (ValW-ByteW)'(0)};
        cnt_q <= MulSteps;
      end
      OP_MUL_STEP: begin
        acc_q <= add_r[ValW-1:0];
        sh_q  <= {sh_q[ValW-2:0], 1'b0};
        cnt_q <= cnt_q - CntW'(1);
      end
      OP_MUL_DONE: begin
        z_q <= acc_q;
        k_q <= k_q - ValW'(1);
      end
      OP_OUT_LOAD: begin
        oc_q   <= z_q;
        on_q   <= n_q[ValW-1:0];
        oe_q   <= e_q;
        od_q   <= err_q ? '0 : d_q;
        oerr_q <= err_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign cipher_value_o = oc_q;
  assign modulus_o      = on_q;
  assign public_exp_o   = oe_q;
  assign private_exp_o  = od_q;
  assign key_error_o    = oerr_q;

endmodule

// ----- hdl/srsa_check.sv -----
// Port-level checker for the small RSA block, bound to the top level.
module srsa_check (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [srsa_pkg::ValW-1:0]   cipher_value_o,
  input logic [srsa_pkg::ValW-1:0]   modulus_o,
  input logic [srsa_pkg::ValW-1:0]   private_exp_o,
  input logic                        key_error_o
);

  // one byte at a time: no transfer in right after another
  a_in_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken in back-to-back cycles");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result dropped while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && key_error_o) |-> (cipher_value_o == '0 && private_exp_o == '0))
    else $error("key error with nonzero cipher or private exponent");

  a_cipher_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !key_error_o) |-> (cipher_value_o < modulus_o))
    else $error("cipher not reduced mod n");

endmodule

bind small_rsa_key_and_encrypt srsa_check u_srsa_check (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .cipher_value_o (cipher_value_o),
  .modulus_o      (modulus_o),
  .private_exp_o  (private_exp_o),
  .key_error_o    (key_error_o)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the small RSA key derivation and byte encryption block.
module testbench;
  import srsa_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned RANDOM_BYTES = 266;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned IDLE_PCT     = 22;

  typedef struct packed {
    logic [ValW-1:0] cipher;
    logic [ValW-1:0] modulus;
    logic [ValW-1:0] pub_exp;
    logic [ValW-1:0] priv_exp;
    logic            key_err;
  } rsa_result_t;

  class rsa_scoreboard;
    int unsigned   prime_p;
    int unsigned   prime_q;
    bit            have_key;
    int unsigned   n_val;
    int unsigned   e_val;
    int unsigned   d_val;
    bit            bad_key;
    rsa_result_t   expected_q[$];
    int unsigned   mismatches;

    function new();
      prime_p    = 5;
      prime_q    = 7;
      have_key   = 1'b0;
      n_val      = 0;
      e_val      = 0;
      d_val      = 0;
      bad_key    = 1'b0;
      mismatches = 0;
    endfunction

    function bit is_prime(int unsigned v);
      int unsigned k;
      if (v <= 1) return 1'b0;
      for (k = 2; k <= v / 2; k++)
        if (v % k == 0) return 1'b0;
      return 1'b1;
    endfunction

    function int unsigned gcd_of(int unsigned a, int unsigned b);
      int unsigned t;
      while (b != 0) begin
        t = b;
        b = a % b;
        a = t;
      end
      return a;
    endfunction

    // n, e and d from the current primes; e stays visible when no inverse exists
    function void build_key();
      int unsigned fi;
      int unsigned cand;
      int unsigned k;
      n_val    = (prime_p * prime_q) & 'hFFF;
      e_val    = 0;
      d_val    = 0;
      bad_key  = 1'b1;
      have_key = 1'b1;
      if (!is_prime(prime_p) || !is_prime(prime_q) || prime_p == prime_q ||
          prime_p > PRIME_LIMIT || prime_q > PRIME_LIMIT)
        return;
      fi   = (prime_p - 1) * (prime_q - 1);
      cand = 2;
      while (cand < fi && gcd_of(cand, fi) != 1) cand++;
      e_val = cand & 'h7FF;
      if (fi < 2 || gcd_of(cand, fi) != 1) return;
      for (k = 1; k <= fi; k++) begin
        if ((k * cand) % fi == 1) begin
          d_val   = k & 'h7FF;
          bad_key = 1'b0;
          return;
        end
      end
    endfunction

    function void set_prime(srsa_reg_e idx, logic [PrimeW-1:0] v);
      if (idx == REG_PRIME_P) prime_p = 32'(v);
      else prime_q = 32'(v);
      have_key = 1'b0;
    endfunction

    function void note_byte(logic [ByteW-1:0] m);
      rsa_result_t r;
      int unsigned z;
      int unsigned k;
      if (!have_key) build_key();
      z = 0;
      if (!bad_key && n_val != 0) begin
        z = 1;
        for (k = 1; k <= e_val; k++) z = (z * m) % n_val;
      end
      r.cipher   = ValW'(z);
      r.modulus  = ValW'(n_val);
      r.pub_exp  = ValW'(e_val);
      r.priv_exp = bad_key ? '0 : ValW'(d_val);
      r.key_err  = bad_key;
      expected_q.push_back(r);
    endfunction

    function void check_field(string name, logic [ValW-1:0] want, logic [ValW-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(logic [ValW-1:0] cipher, logic [ValW-1:0] modulus,
                               logic [ValW-1:0] pub_exp, logic [ValW-1:0] priv_exp,
                               logic key_err);
      rsa_result_t want;
      if (expected_q.size() == 0) begin
        $error("result with no byte outstanding: cipher_value %0d", cipher);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      check_field("cipher_value", want.cipher, cipher);
      check_field("modulus", want.modulus, modulus);
      check_field("public_exp", want.pub_exp, pub_exp);
      check_field("private_exp", want.priv_exp, priv_exp);
      check_field("key_error", ValW'(want.key_err), ValW'(key_err));
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic              cfg_index_i;
  logic [PrimeW-1:0] cfg_data_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [ByteW-1:0]  plain_byte_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [ValW-1:0]   cipher_value_o;
  logic [ValW-1:0]   modulus_o;
  logic [ValW-1:0]   public_exp_o;
  logic [ValW-1:0]   private_exp_o;
  logic              key_error_o;

  rsa_scoreboard sb;
  int unsigned   gap_pct = IDLE_PCT;
  bit            hold_req = 1'b0;
  int unsigned   cycle_count = 0;
  int unsigned   small_primes[15] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47};

  small_rsa_key_and_encrypt i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .plain_byte_i  (plain_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .cipher_value_o(cipher_value_o),
    .modulus_o     (modulus_o),
    .public_exp_o  (public_exp_o),
    .private_exp_o (private_exp_o),
    .key_error_o   (key_error_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: random stalls, or one long hold-off on request
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_stall_i <= ($urandom_range(99) < gap_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(cipher_value_o, modulus_o, public_exp_o, private_exp_o, key_error_o);
  end

  // Valid stays high from one transfer to the next unless a gap is drawn
  task automatic send_byte(input logic [ByteW-1:0] value);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    plain_byte_i <= value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_byte(value);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Only called with bytes in between, so cfg_we_i never gets two updates in one step
  task automatic load_primes(input logic [PrimeW-1:0] p, input logic [PrimeW-1:0] q,
                             input bit set_p, input bit set_q);
    drain();
    if (set_p) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= REG_PRIME_P;
      cfg_data_i  <= p;
      @(posedge clk_i);
      sb.set_prime(REG_PRIME_P, p);
    end
    if (set_q) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= REG_PRIME_Q;
      cfg_data_i  <= q;
      @(posedge clk_i);
      sb.set_prime(REG_PRIME_Q, q);
    end
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int unsigned       sent;
    int unsigned       phase;
    int unsigned       burst;
    int unsigned       j;
    logic [PrimeW-1:0] p;
    logic [PrimeW-1:0] q;
    logic [ByteW-1:0]  value;
    bit                set_p;
    sb = new();
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_index_i  <= REG_PRIME_P;
    cfg_data_i   <= '0;
    in_valid_i   <= 1'b0;
    plain_byte_i <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset primes 5 and 7 (n = 35): byte extremes and bytes at and above n
    send_byte(8'd0);
    send_byte(8'd1);
    send_byte(8'd255);
    send_byte(8'd35);
    send_byte(8'd36);
    send_byte(8'd2);
    // zero and a composite at the top of the range
    load_primes(6'd0, 6'd63, 1'b1, 1'b1);
    send_byte(8'd0);
    send_byte(8'd255);
    // prime above the limit
    load_primes(6'd53, 6'd7, 1'b1, 1'b1);
    send_byte(8'd0);
    send_byte(8'd255);
    // equal primes
    load_primes(6'd7, 6'd7, 1'b1, 1'b0);
    send_byte(8'd0);
    send_byte(8'd255);
    // no coprime exponent below fi
    load_primes(6'd2, 6'd3, 1'b1, 1'b1);
    send_byte(8'd0);
    send_byte(8'd255);
    load_primes(6'd1, 6'd13, 1'b1, 1'b1);
    send_byte(8'd0);
    send_byte(8'd255);
    // largest valid key
    load_primes(6'd47, 6'd43, 1'b1, 1'b1);
    send_byte(8'd0);
    send_byte(8'd255);
    send_byte(8'd170);
    send_byte(8'd85);

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_BYTES) begin
      if ($urandom_range(99) < 75) begin
        p = PrimeW'(small_primes[$urandom_range(14)]);
        do q = PrimeW'(small_primes[$urandom_range(14)]); while (q == p);
      end else begin
        p = PrimeW'($urandom_range(63));
        q = PrimeW'($urandom_range(63));
      end
      set_p = ($urandom_range(3) != 0);
      load_primes(p, q, set_p, !set_p || ($urandom_range(3) != 0));
      gap_pct = (phase == 2) ? 0 : IDLE_PCT;
      if (phase == 4) hold_req = 1'b1;
      burst = $urandom_range(10, 40);
      if (burst > RANDOM_BYTES - sent) burst = RANDOM_BYTES - sent;
      for (j = 0; j < burst; j++) begin
        if ($urandom_range(9) == 0) value = $urandom_range(1) ? 8'hFF : 8'h00;
        else value = ByteW'($urandom_range(255));
        send_byte(value);
        sent++;
      end
      phase++;
    end

    gap_pct = IDLE_PCT;
    drain();
    repeat (300) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
